// File: src/pcm_fd_pkg.sv
// pcm_fd_pkg: shared types and constants for the PCM frame downmix block.
// Used by pcm_fd_frontend, pcm_fd_divider and pcm_frame_downmix.
// No dependencies.
package pcm_fd_pkg;

	// configuration port
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

	// register widths and reset values
	localparam int FMT_W = 3;
	localparam int CH_W  = 4;
	localparam logic [FMT_W-1:0] FMT_RESET = 3'd1;
	localparam logic [CH_W-1:0]  CH_RESET  = 4'd2;

	// sample format codes
	localparam logic [FMT_W-1:0] FMT_U8  = 3'd0;
	localparam logic [FMT_W-1:0] FMT_S16 = 3'd1;
	localparam logic [FMT_W-1:0] FMT_S24 = 3'd2;
	localparam logic [FMT_W-1:0] FMT_S32 = 3'd3;
	localparam logic [FMT_W-1:0] FMT_F32 = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_HOLD
	} state_t;

	// frame assembly status, valid in the cycle of the input transfer
	typedef struct packed {
		logic frame_done;
		logic frame_last;
	} fe_status_t;

	// divider status
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

endpackage

// File: src/pcm_frame_downmix.sv
// pcm_frame_downmix: mono downmix of WAV PCM data-chunk bytes, top level.
// Instantiates pcm_fd_frontend and pcm_fd_divider; depends on pcm_fd_pkg.
//
// Usage:
//  - s_axis carries one data-chunk byte per transfer (tdata), tlast flags the
//    final byte of the stream. A partial frame at tlast is dropped.
//  - m_axis carries one Q1.31 mono sample per completed frame (tdata), tlast
//    set when that frame was completed by the final input byte.
//  - cfg writes sample_format (addr 0) or channel_count (addr 1); any valid
//    write drops the partial sample and frame. Other addresses are ignored.
// Timing:
//  - a byte that does not complete a frame is accepted with no stall.
//  - a byte that completes a frame starts the serial divider: a magnitude
//    step, then one quotient bit per cycle, until the result is in the
//    output register; s_axis_tready and cfg_ready stay low meanwhile.
//  - the output register decouples the sides: bytes keep flowing while a
//    result waits. If the divider finishes while the receiver stalls, the
//    result is held in the divider until the output register frees.
// Reset: registers to 1 (signed 16) and 2 channels, frame state cleared,
//   no result pending.
module pcm_frame_downmix #(
	parameter int MAX_CHANNELS = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// byte stream in
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
	input  logic                              s_axis_tlast,   // last_byte
	// mono stream out
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [31:0]                       m_axis_tdata,   // [31:0] mono_sample
	output logic                              m_axis_tlast,   // stream_end
	// register writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [pcm_fd_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [pcm_fd_pkg::CFG_DATA_W-1:0] cfg_data
);

	// sum of up to MAX_CHANNELS Q1.31 samples plus a sign bit of headroom
	localparam int SUM_W = 33 + $clog2(MAX_CHANNELS);

	pcm_fd_pkg::state_t state_q, state_d;

	logic [pcm_fd_pkg::FMT_W-1:0] sample_format_q;
	logic [pcm_fd_pkg::CH_W-1:0]  channel_count_q;
	logic [pcm_fd_pkg::CH_W-1:0]  channels;

	logic                    m_valid_q;
	logic [31:0]             m_data_q;
	logic                    m_last_q;
	logic                    frame_last_q;

	logic                    in_xfer;
	logic                    cfg_xfer;
	logic                    cfg_hit;
	logic                    out_free;
	logic                    load_out;

	pcm_fd_pkg::fe_status_t  fe_st;
	pcm_fd_pkg::div_status_t div_st;
	logic signed [SUM_W-1:0] frame_sum;
	logic signed [31:0]      quotient;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign cfg_xfer = cfg_valid && cfg_ready;
	assign cfg_hit  = cfg_xfer && (cfg_addr == pcm_fd_pkg::CFG_SAMPLE_FORMAT ||
	                               cfg_addr == pcm_fd_pkg::CFG_CHANNEL_COUNT);
	assign out_free = !m_valid_q || m_axis_tready;

	// zero counts as one channel; clamp to the build limit
	always_comb begin
		if (channel_count_q == '0) begin
			channels = pcm_fd_pkg::CH_W'(1);
		end else if (32'(channel_count_q) > MAX_CHANNELS) begin
			channels = pcm_fd_pkg::CH_W'(MAX_CHANNELS);
		end else begin
			channels = channel_count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_format_q <= pcm_fd_pkg::FMT_RESET;
			channel_count_q <= pcm_fd_pkg::CH_RESET;
		end else if (cfg_xfer) begin
			if (cfg_addr == pcm_fd_pkg::CFG_SAMPLE_FORMAT) begin
				sample_format_q <= cfg_data[pcm_fd_pkg::FMT_W-1:0];
			end else if (cfg_addr == pcm_fd_pkg::CFG_CHANNEL_COUNT) begin
				channel_count_q <= cfg_data;
			end
		end
	end

	pcm_fd_frontend #(
		.SUM_W(SUM_W)
	) u_frontend (
		.clk          (clk),
		.arst_n       (arst_n),
		.clear        (cfg_hit),
		.accept       (in_xfer),
		.data_byte    (s_axis_tdata),
		.last_byte    (s_axis_tlast),
		.sample_format(sample_format_q),
		.channels     (channels),
		.status       (fe_st),
		.frame_sum    (frame_sum)
	);

	pcm_fd_divider #(
		.SUM_W(SUM_W)
	) u_divider (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (fe_st.frame_done),
		.dividend(frame_sum),
		.divisor (channels),
		.status  (div_st),
		.quotient(quotient)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pcm_fd_pkg::ST_IDLE: begin
				if (fe_st.frame_done) begin
					state_d = pcm_fd_pkg::ST_DIVIDE;
				end
			end
			pcm_fd_pkg::ST_DIVIDE: begin
				if (div_st.done) begin
					state_d = out_free ? pcm_fd_pkg::ST_IDLE : pcm_fd_pkg::ST_HOLD;
				end
			end
			pcm_fd_pkg::ST_HOLD: begin
				if (out_free) begin
					state_d = pcm_fd_pkg::ST_IDLE;
				end
			end
			default: state_d = pcm_fd_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		s_axis_tready = 1'b0;
		cfg_ready     = 1'b0;
		load_out      = 1'b0;
		case (state_q)
			pcm_fd_pkg::ST_IDLE: begin
				s_axis_tready = 1'b1;
				cfg_ready     = 1'b1;
			end
			pcm_fd_pkg::ST_DIVIDE: load_out = div_st.done && out_free;
			pcm_fd_pkg::ST_HOLD:   load_out = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pcm_fd_pkg::ST_IDLE;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fe_st.frame_done) begin
			frame_last_q <= fe_st.frame_last;
		end
		if (load_out) begin
			m_data_q <= quotient;
			m_last_q <= frame_last_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_no_input_while_dividing: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !div_st.busy)
		else $error("input ready while divider busy");

	a_done_only_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == pcm_fd_pkg::ST_DIVIDE)
		else $error("divider result with no frame pending");

	a_hold_means_output_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pcm_fd_pkg::ST_HOLD |-> m_axis_tvalid)
		else $error("result held while output register empty");

	a_frame_starts_divide: assert property (@(posedge clk) disable iff (!arst_n)
		fe_st.frame_done |=> div_st.busy && state_q == pcm_fd_pkg::ST_DIVIDE)
		else $error("completed frame did not start the divider");
`endif

endmodule

// File: src/pcm_fd_frontend.sv
// pcm_fd_frontend: byte assembly, Q1.31 conversion and frame accumulation.
// Depends on pcm_fd_pkg.
module pcm_fd_frontend #(
	parameter int SUM_W = 36
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            clear,
	input  logic                            accept,
	input  logic [7:0]                      data_byte,
	input  logic                            last_byte,
	input  logic [pcm_fd_pkg::FMT_W-1:0]    sample_format,
	input  logic [pcm_fd_pkg::CH_W-1:0]     channels,
	output pcm_fd_pkg::fe_status_t          status,
	output logic signed [SUM_W-1:0]         frame_sum
);

	localparam logic [7:0] EXP_ONE = 8'd127;  // 1.0 and above saturates
	localparam logic [7:0] EXP_INT = 8'd119;  // mantissa lands unshifted

	function automatic logic signed [31:0] to_q31(
		input logic [pcm_fd_pkg::FMT_W-1:0] fmt,
		input logic [31:0]                  raw
	);
		logic [7:0]  expo;
		logic [22:0] frac;
		logic [31:0] mant;
		logic [31:0] mag;
		logic [7:0]  rsh;
		logic [7:0]  lsh;
		expo = raw[30:23];
		frac = raw[22:0];
		mant = {8'b0, 1'b1, frac};
		rsh  = EXP_INT - expo;
		lsh  = expo - EXP_INT;
		mag  = '0;
		case (fmt)
			pcm_fd_pkg::FMT_U8:  return {~raw[7], raw[6:0], 24'b0};
			pcm_fd_pkg::FMT_S16: return {raw[15:0], 16'b0};
			pcm_fd_pkg::FMT_S24: return {raw[23:0], 8'b0};
			pcm_fd_pkg::FMT_S32: return raw;
			pcm_fd_pkg::FMT_F32: begin
				if (expo == 8'hFF && frac != '0) begin
					return '0;                       // NaN
				end else if (expo >= EXP_ONE) begin
					return raw[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end else if (expo == '0) begin
					return '0;                       // zero and denormals
				end else if (expo >= EXP_INT) begin
					mag = mant << lsh[2:0];
				end else if (rsh >= 8'd32) begin
					mag = '0;
				end else begin
					mag = mant >> rsh[4:0];
				end
				return raw[31] ? -mag : mag;
			end
			default: return '0;
		endcase
	endfunction

	logic [23:0]             sample_bytes_q;
	logic [1:0]              byte_pos_q;
	logic [pcm_fd_pkg::CH_W-1:0] ch_pos_q;
	logic signed [SUM_W-1:0] frame_sum_q;

	logic [2:0]              nbytes;
	logic                    sample_open;
	logic [31:0]             raw;
	logic signed [31:0]      q31;
	logic signed [SUM_W-1:0] sum_next;
	logic [pcm_fd_pkg::CH_W-1:0] ch_next;
	logic                    frame_open;

	always_comb begin
		case (sample_format)
			pcm_fd_pkg::FMT_U8:  nbytes = 3'd1;
			pcm_fd_pkg::FMT_S16: nbytes = 3'd2;
			pcm_fd_pkg::FMT_S24: nbytes = 3'd3;
			default:             nbytes = 3'd4;
		endcase
	end

	assign sample_open = ({1'b0, byte_pos_q} + 3'd1) < nbytes;
	assign raw         = {8'b0, sample_bytes_q} | ({24'b0, data_byte} << {byte_pos_q, 3'b0});
	assign q31         = to_q31(sample_format, raw);
	assign sum_next    = frame_sum_q + SUM_W'(q31);
	assign ch_next     = ch_pos_q + 1'b1;
	assign frame_open  = ch_next < channels;

	assign status.frame_done = accept && !sample_open && !frame_open;
	assign status.frame_last = last_byte;
	assign frame_sum         = sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bytes_q <= '0;
			byte_pos_q     <= '0;
			ch_pos_q       <= '0;
			frame_sum_q    <= '0;
		end else if (clear || (accept && (last_byte || status.frame_done))) begin
			sample_bytes_q <= '0;
			byte_pos_q     <= '0;
			ch_pos_q       <= '0;
			frame_sum_q    <= '0;
		end else if (accept) begin
			if (sample_open) begin
				sample_bytes_q <= raw[23:0];
				byte_pos_q     <= byte_pos_q + 1'b1;
			end else begin
				sample_bytes_q <= '0;
				byte_pos_q     <= '0;
				ch_pos_q       <= ch_next;
				frame_sum_q    <= sum_next;
			end
		end
	end

endmodule

// File: src/pcm_fd_divider.sv
// pcm_fd_divider: serial restoring divider, one quotient bit per cycle.
// Signed dividend over a small unsigned divisor, truncated toward zero.
// Depends on pcm_fd_pkg.
module pcm_fd_divider #(
	parameter int SUM_W = 36
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [SUM_W-1:0]     dividend,
	input  logic [pcm_fd_pkg::CH_W-1:0] divisor,
	output pcm_fd_pkg::div_status_t     status,
	output logic signed [31:0]          quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]            quo_q;
	logic [pcm_fd_pkg::CH_W-1:0] rem_q;
	logic [pcm_fd_pkg::CH_W-1:0] div_q;
	logic                        neg_q;
	logic                        abs_q;
	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;

	logic [pcm_fd_pkg::CH_W:0]   trial;
	logic                        take;
	logic [pcm_fd_pkg::CH_W:0]   diff;

	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign take  = trial >= {1'b0, div_q};
	assign diff  = trial - {1'b0, div_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			abs_q  <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				abs_q  <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (abs_q) begin
					abs_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(SUM_W - 1)) begin
						busy_q <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	// datapath: first cycle takes the magnitude, then one bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			neg_q <= dividend[SUM_W-1];
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (abs_q) begin
				if (neg_q) begin
					quo_q <= -quo_q;
				end
			end else begin
				quo_q <= {quo_q[SUM_W-2:0], take};
				rem_q <= take ? diff[pcm_fd_pkg::CH_W-1:0] : trial[pcm_fd_pkg::CH_W-1:0];
			end
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign quotient    = neg_q ? -quo_q[31:0] : quo_q[31:0];

endmodule
